/* hdl/rpe_pkg.sv */
// Package for the run-length pair encoder: queue record type and constants.
// Used by rpe_front, rpe_back, rpe_fifo and rle_pair_encoder_core.
package rpe_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] blen_t;

    localparam byte_t MAX_RUN      = 8'd255;
    localparam blen_t BLEN_RESET   = 16'd4096;

    // One classified input: up to two pairs to be sent by the back end.
    typedef struct packed {
        logic  close_valid;  // previous run closed by this byte
        byte_t close_count;
        byte_t close_value;
        logic  flush_valid;  // pending run flushed at block or stream end
        byte_t flush_count;
        byte_t flush_value;
        logic  fin;          // flush was caused by stream end
    } pair_rec_t;

endpackage

/* hdl/rpe_fifo.sv */
// Small flip-flop queue between front and back ends of the pair encoder.
// Depends on rpe_pkg for the record type.
module rpe_fifo
    import rpe_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  pair_rec_t wr_data,
    input  logic      rd_en,
    output pair_rec_t rd_data,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pair_rec_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/rpe_front.sv */
// Front end of the pair encoder: run tracking, block position, classification.
// Depends on rpe_pkg; pushes one record per input that closes or flushes a run.
module rpe_front
    import rpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  blen_t     cfg_wdata,
    input  logic      in_take,
    input  byte_t     data_byte,
    input  logic      stream_end,
    output logic      rec_push,
    output pair_rec_t rec
);

    blen_t       block_length_reg;
    logic        run_active_reg;
    logic        run_active_next;
    byte_t       cur_value_reg;
    byte_t       cur_value_next;
    byte_t       cur_count_reg;
    byte_t       cur_count_next;
    blen_t       block_pos_reg;
    blen_t       block_pos_next;

    logic [16:0] eff_len;
    logic [16:0] next_pos;
    logic        flush;
    logic        extend;
    byte_t       upd_value;
    byte_t       upd_count;

    always_comb
    begin
        eff_len  = (block_length_reg == '0) ? 17'h10000 : {1'b0, block_length_reg};
        next_pos = {1'b0, block_pos_reg} + 17'd1;
        flush    = stream_end || (next_pos >= eff_len);
        extend   = run_active_reg && (data_byte == cur_value_reg)
                   && (cur_count_reg != MAX_RUN);

        if (extend)
        begin
            upd_value = cur_value_reg;
            upd_count = cur_count_reg + 8'd1;
        end
        else
        begin
            upd_value = data_byte;
            upd_count = 8'd1;
        end

        rec.close_valid = run_active_reg && !extend;
        rec.close_count = cur_count_reg;
        rec.close_value = cur_value_reg;
        rec.flush_valid = flush;
        rec.flush_count = upd_count;
        rec.flush_value = upd_value;
        rec.fin         = stream_end;
        rec_push        = in_take && (rec.close_valid || flush);

        run_active_next = run_active_reg;
        cur_value_next  = cur_value_reg;
        cur_count_next  = cur_count_reg;
        block_pos_next  = block_pos_reg;
        if (in_take)
        begin
            if (flush)
            begin
                run_active_next = 1'b0;
                cur_value_next  = '0;
                cur_count_next  = '0;
                block_pos_next  = '0;
            end
            else
            begin
                run_active_next = 1'b1;
                cur_value_next  = upd_value;
                cur_count_next  = upd_count;
                block_pos_next  = next_pos[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLEN_RESET;
            run_active_reg   <= 1'b0;
            cur_value_reg    <= '0;
            cur_count_reg    <= '0;
            block_pos_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_length_reg <= cfg_wdata;
            end
            run_active_reg <= run_active_next;
            cur_value_reg  <= cur_value_next;
            cur_count_reg  <= cur_count_next;
            block_pos_reg  <= block_pos_next;
        end
    end

endmodule

/* hdl/rpe_back.sv */
// Back end of the pair encoder: unpacks each queued record into one or two pairs.
// Depends on rpe_pkg; reads the head of rpe_fifo.
module rpe_back
    import rpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pair_rec_t head,
    input  logic      head_empty,
    input  logic      pop,
    output logic      head_pop,
    output logic      empty,
    output byte_t     run_count,
    output byte_t     run_value,
    output logic      last_of_input,
    output logic      final_pair
);

    logic second_reg;
    logic second_next;
    logic send_close;
    logic transfer;

    always_comb
    begin
        send_close = head.close_valid && !second_reg;
        empty      = head_empty;
        transfer   = pop && !head_empty;

        if (send_close)
        begin
            run_count     = head.close_count;
            run_value     = head.close_value;
            last_of_input = !head.flush_valid;
            final_pair    = 1'b0;
        end
        else
        begin
            run_count     = head.flush_count;
            run_value     = head.flush_value;
            last_of_input = 1'b1;
            final_pair    = head.fin;
        end

        // Hold the record while its flushed pair is still to be sent.
        second_next = second_reg;
        head_pop    = 1'b0;
        if (transfer)
        begin
            if (send_close && head.flush_valid)
            begin
                second_next = 1'b1;
            end
            else
            begin
                second_next = 1'b0;
                head_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
        end
    end

endmodule

/* hdl/rle_pair_encoder_core.sv */
// Run-length pair encoder, top level: front end, record queue, back end.
// Depends on rpe_pkg, rpe_front, rpe_fifo and rpe_back.
//
// Input channel: data_byte/stream_end transfer when push is high and full is low.
// Result channel: while empty is low, the oldest (run_count, run_value,
// last_of_input, final_pair) pair is on the ports; it transfers when pop is high.
// Configuration: cfg_we writes cfg_wdata into block_length (reset 4096; zero
// means 65536 bytes). Write it only while the block is idle.
// Each byte closes the current run when it differs or the count is 255, and
// the pending run is flushed at each block end and on stream_end, so a byte
// yields zero, one or two pairs.
// Records pass through the record queue registers; a pair is on the result
// ports once its record heads the queue. Throughput: one byte per cycle while
// full is low; the back end sends one pair per cycle while pop is high.
// The record queue is QUEUE_DEPTH entries deep; when the receiver stalls it
// fills and full rises. Reset empties the queue, clears the run state and
// sets block_length to 4096.
module rle_pair_encoder_core
    import rpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  run_count,
    output logic [7:0]  run_value,
    output logic        last_of_input,
    output logic        final_pair
);

    logic      in_take;
    logic      rec_push;
    pair_rec_t rec;
    pair_rec_t head;
    logic      head_empty;
    logic      head_pop;
    logic      q_full;

    assign full    = q_full;
    assign in_take = push && !q_full;

    rpe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_take    (in_take),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .rec_push   (rec_push),
        .rec        (rec)
    );

    rpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec),
        .rd_en   (head_pop),
        .rd_data (head),
        .full    (q_full),
        .empty   (head_empty)
    );

    rpe_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_empty    (head_empty),
        .pop           (pop),
        .head_pop      (head_pop),
        .empty         (empty),
        .run_count     (run_count),
        .run_value     (run_value),
        .last_of_input (last_of_input),
        .final_pair    (final_pair)
    );

endmodule
